// File: rtl/core/icb_pkg.sv
// Shared types, constants and sum helpers for the ICMPv6 checksum builder.
package icb_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [15:0] NEXT_HEADER_ICMPV6 = 16'd58;
    localparam logic [15:0] LENGTH_START       = 16'd4;
    localparam logic [15:0] WORD_MAX           = 16'hFFFF;

    // One entry of the queue between the front and the back.
    typedef struct packed {
        logic        op;
        logic        last;
        logic [7:0]  data_byte;
        logic [15:0] pre_sum;
    } t_entry;

    // Plain sum of the four 16-bit words of a quad.
    function automatic logic [17:0] quad_sum(input logic [63:0] v);
        quad_sum = 18'(v[63:48]) + 18'(v[47:32]) + 18'(v[31:16]) + 18'(v[15:0]);
    endfunction

    // Fold a plain sum into the 16-bit end-around form.
    function automatic logic [15:0] fold_sum(input logic [20:0] x);
        logic [16:0] y;
        y        = 17'(x[15:0]) + 17'(x[20:16]);
        fold_sum = y[15:0] + 16'(y[16]);
    endfunction

endpackage

// File: rtl/core/icb_front.sv
// Front end: accept requests, pre-sum the pseudo-header and feed the queue.
module icb_front import icb_pkg::*; #(
    parameter int DEPTH = 4,
    parameter int CW    = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic          i_op,
    input  logic [63:0]   i_src_high,
    input  logic [63:0]   i_src_low,
    input  logic [63:0]   i_dst_high,
    input  logic [63:0]   i_dst_low,
    input  logic [7:0]    i_msg_type,
    input  logic [7:0]    i_msg_code,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last,
    input  logic [CW-1:0] i_q_count,
    output logic          o_wr_en,
    output t_entry        o_wr_entry
);

    logic        r_s1_valid;
    logic        r_s1_op;
    logic        r_s1_last;
    logic [7:0]  r_s1_byte;
    logic [18:0] r_s1_part [4];

    logic        r_s2_valid;
    logic        r_s2_op;
    logic        r_s2_last;
    logic [7:0]  r_s2_byte;
    logic [20:0] r_s2_total;

    logic        accept;
    logic [CW:0] in_flight;

    // Requests in the pipe plus queued entries never exceed the queue depth.
    assign in_flight = {1'b0, i_q_count} + (CW+1)'(r_s1_valid) + (CW+1)'(r_s2_valid);
    assign o_full    = in_flight >= (CW+1)'(DEPTH);
    assign accept    = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_op      <= i_op;
        r_s1_last    <= i_last;
        r_s1_byte    <= i_data_byte;
        r_s1_part[0] <= 19'(quad_sum(i_src_high)) + 19'(NEXT_HEADER_ICMPV6);
        r_s1_part[1] <= 19'(quad_sum(i_src_low)) + 19'({i_msg_type, i_msg_code});
        r_s1_part[2] <= 19'(quad_sum(i_dst_high));
        r_s1_part[3] <= 19'(quad_sum(i_dst_low));

        r_s2_op      <= r_s1_op;
        r_s2_last    <= r_s1_last;
        r_s2_byte    <= r_s1_byte;
        r_s2_total   <= 21'(r_s1_part[0]) + 21'(r_s1_part[1])
                      + 21'(r_s1_part[2]) + 21'(r_s1_part[3]);
    end

    assign o_wr_en              = r_s2_valid;
    assign o_wr_entry.op        = r_s2_op;
    assign o_wr_entry.last      = r_s2_last;
    assign o_wr_entry.data_byte = r_s2_byte;
    assign o_wr_entry.pre_sum   = fold_sum(r_s2_total);

endmodule

// File: rtl/core/icb_queue.sv
// Short queue that decouples the front end from the accumulator.
module icb_queue import icb_pkg::*; #(
    parameter int DEPTH = 4,
    parameter int PW    = 2,
    parameter int CW    = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  t_entry        i_wr_entry,
    input  logic          i_rd_en,
    output logic          o_rd_valid,
    output t_entry        o_rd_entry,
    output logic [CW-1:0] o_count
);

    t_entry        mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_rd;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        next_ptr = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign do_rd      = i_rd_en && (r_count != '0);
    assign o_rd_valid = r_count != '0;
    assign o_rd_entry = mem[r_rd_ptr];
    assign o_count    = r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[r_wr_ptr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (do_rd) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (i_wr_en && !do_rd) begin
                r_count <= r_count + CW'(1);
            end else if (!i_wr_en && do_rd) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// File: rtl/core/icb_back.sv
// Back end: running end-around sum, byte pairing, length and result register.
module icb_back import icb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rd_valid,
    input  t_entry      i_rd_entry,
    output logic        o_rd_en,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [15:0] o_checksum,
    output logic [15:0] o_message_length,
    output logic        o_too_long
);

    logic [15:0] r_sum;
    logic [15:0] r_count;
    logic [7:0]  r_held;
    logic        r_odd;
    logic        r_ovf;

    logic        r_out_valid;
    logic [15:0] r_out_checksum;
    logic [15:0] r_out_length;
    logic        r_out_too_long;

    logic        out_free;
    logic        take;
    logic        is_start;
    logic [15:0] base;
    logic [15:0] word;
    logic [15:0] count_new;
    logic        ovf_new;
    logic [15:0] sum_new;
    logic [15:0] n_sum;
    logic [7:0]  n_held;
    logic        n_odd;

    assign out_free = !r_out_valid || i_pop;
    assign take     = i_rd_valid && (!i_rd_entry.last || out_free);
    assign o_rd_en  = take;
    assign is_start = i_rd_entry.op == OP_START;

    always_comb begin
        base = is_start ? i_rd_entry.pre_sum : r_sum;
        word = '0;
        if (!is_start) begin
            if (r_odd) begin
                word = {r_held, i_rd_entry.data_byte};
            end else if (i_rd_entry.last) begin
                word = {i_rd_entry.data_byte, 8'h00};
            end
        end
        if (is_start) begin
            count_new = LENGTH_START;
            ovf_new   = 1'b0;
            n_held    = '0;
            n_odd     = 1'b0;
        end else begin
            count_new = (r_count == WORD_MAX) ? WORD_MAX : r_count + 16'd1;
            ovf_new   = r_ovf || (r_count == WORD_MAX);
            n_held    = r_odd ? 8'h00 : i_rd_entry.data_byte;
            n_odd     = !r_odd;
        end
        // Three-way add folds to the same value as adding the words one by one.
        sum_new = fold_sum(21'(base) + 21'(word)
                           + 21'(i_rd_entry.last ? count_new : 16'h0000));
        n_sum   = sum_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_count     <= '0;
            r_held      <= '0;
            r_odd       <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                if (i_rd_entry.last) begin
                    r_sum   <= '0;
                    r_count <= '0;
                    r_held  <= '0;
                    r_odd   <= 1'b0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_sum   <= n_sum;
                    r_count <= count_new;
                    r_held  <= n_held;
                    r_odd   <= n_odd;
                    r_ovf   <= ovf_new;
                end
            end
            if (take && i_rd_entry.last) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_rd_entry.last) begin
            r_out_checksum <= ~sum_new;
            r_out_length   <= count_new;
            r_out_too_long <= ovf_new;
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_checksum       = r_out_checksum;
    assign o_message_length = r_out_length;
    assign o_too_long       = r_out_too_long;

endmodule

// File: rtl/core/icmpv6_checksum_builder_unit.sv
// Top level of the ICMPv6 checksum builder.
//
// Input channel (push/full): a start request (op = 0) carries the source and
// destination addresses as 64-bit halves plus type and code; data requests
// (op = 1) carry one message byte each. last ends the message; on a start
// request it means the message has no data. A request is taken on a rising
// edge with push high and full low.
// Result channel (empty/pop): one result per message, holding the
// complemented end-around sum, the message length (4 + data bytes,
// saturated at 65535) and too_long. It is taken on an edge with pop high and
// empty low.
// Throughput: one request per cycle while no last request waits on a held
// result. The front end pre-sums the eighteen pseudo-header words in two
// register stages, then the back end does one three-way end-around add per
// request. A last request passes the two front stages, the queue and the result register before empty goes low.
// Stall: a waiting result holds in the output register while data requests
// keep flowing into the accumulator; a last request waits in the queue, and
// full rises once the queue plus the two front stages hold QUEUE_DEPTH.
// Reset (synchronous, active low) empties the queue and the result register
// and clears the running sum, length and byte pairing.
module icmpv6_checksum_builder_unit import icb_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_op,
    input  logic [63:0] i_src_high,
    input  logic [63:0] i_src_low,
    input  logic [63:0] i_dst_high,
    input  logic [63:0] i_dst_low,
    input  logic [7:0]  i_msg_type,
    input  logic [7:0]  i_msg_code,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_checksum,
    output logic [15:0] o_message_length,
    output logic        o_too_long
);

    // Pointer and fill-count widths of the queue.
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          wr_en;
    t_entry        wr_entry;
    logic          rd_en;
    logic          rd_valid;
    t_entry        rd_entry;
    logic [CW-1:0] q_count;

    // Accept requests and pre-sum the pseudo-header.
    icb_front #(
        .DEPTH (QUEUE_DEPTH),
        .CW    (CW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_op        (i_op),
        .i_src_high  (i_src_high),
        .i_src_low   (i_src_low),
        .i_dst_high  (i_dst_high),
        .i_dst_low   (i_dst_low),
        .i_msg_type  (i_msg_type),
        .i_msg_code  (i_msg_code),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_q_count   (q_count),
        .o_wr_en     (wr_en),
        .o_wr_entry  (wr_entry)
    );

    // Hold classified requests until the accumulator takes them.
    icb_queue #(
        .DEPTH (QUEUE_DEPTH),
        .PW    (PW),
        .CW    (CW)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_entry (wr_entry),
        .i_rd_en    (rd_en),
        .o_rd_valid (rd_valid),
        .o_rd_entry (rd_entry),
        .o_count    (q_count)
    );

    // Accumulate, finish on last and present the result.
    icb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rd_valid       (rd_valid),
        .i_rd_entry       (rd_entry),
        .o_rd_en          (rd_en),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_checksum       (o_checksum),
        .o_message_length (o_message_length),
        .o_too_long       (o_too_long)
    );

endmodule

// File: rtl/core/icb_checker.sv
// Port-level checker for the ICMPv6 checksum builder, with its bind.
module icb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [15:0] o_checksum,
    input logic [15:0] o_message_length,
    input logic        o_too_long
);

    // Reset leaves no result and an open input.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("result or full seen right after reset");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_checksum)
                              && $stable(o_message_length) && $stable(o_too_long)))
        else $error("waiting result changed");

    // Saturation flag comes only with the saturated length.
    a_too_long_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_too_long) |-> (o_message_length == 16'hFFFF))
        else $error("too_long without saturated length");

    // Occupancy grows only through an accepted request.
    a_full_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("full rose without an accepted request");

endmodule

bind icmpv6_checksum_builder_unit icb_checker u_icb_checker (.*);

// File: sim/icmpv6_checksum_builder_unit_tb.sv
// Testbench for the ICMPv6 checksum builder: random and directed messages with a checksum scoreboard.
`timescale 1ns / 1ps

// One request as it is pushed into the block.
typedef struct packed {
    logic        op;
    logic [63:0] src_high;
    logic [63:0] src_low;
    logic [63:0] dst_high;
    logic [63:0] dst_low;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [7:0]  data_byte;
    logic        last;
} t_request;

// One checksum result as it leaves the block.
typedef struct packed {
    logic [15:0] checksum;
    logic [15:0] message_length;
    logic        too_long;
} t_sum_result;

// Tracks the running ones-complement sum of the open message and holds the
// checksums that the block still owes.
class icmpv6_sum_tracker;
    logic [15:0]  run_sum;
    logic [15:0]  msg_length;
    logic [7:0]   pair_byte;
    logic         pair_open;
    logic         length_clipped;
    t_sum_result  owed_sums[$];
    int unsigned  mismatches;

    function new();
        clear_message();
        mismatches = 0;
    endfunction

    function void clear_message();
        run_sum        = '0;
        msg_length     = '0;
        pair_byte      = '0;
        pair_open      = 1'b0;
        length_clipped = 1'b0;
    endfunction

    // End-around add of one 16-bit word.
    function void add_word(logic [15:0] w);
        logic [16:0] s;
        s       = {1'b0, run_sum} + {1'b0, w};
        run_sum = s[15:0] + {15'b0, s[16]};
    endfunction

    function void add_quad(logic [63:0] v);
        for (int k = 3; k >= 0; k--)
            add_word(v[16*k +: 16]);
    endfunction

    function int unsigned pending();
        return owed_sums.size();
    endfunction

    // Advance the sum by one accepted request; queue a checksum on last.
    function void note_request(t_request r);
        t_sum_result e;
        if (r.op == icb_pkg::OP_START) begin
            // A start drops whatever message was open.
            clear_message();
            add_quad(r.src_high);
            add_quad(r.src_low);
            add_quad(r.dst_high);
            add_quad(r.dst_low);
            add_word(icb_pkg::NEXT_HEADER_ICMPV6);
            add_word({r.msg_type, r.msg_code});
            msg_length = icb_pkg::LENGTH_START;
        end else begin
            if (pair_open) begin
                add_word({pair_byte, r.data_byte});
                pair_open = 1'b0;
                pair_byte = '0;
            end else begin
                pair_byte = r.data_byte;
                pair_open = 1'b1;
            end
            if (msg_length == icb_pkg::WORD_MAX)
                length_clipped = 1'b1;
            else
                msg_length = msg_length + 16'd1;
        end
        if (r.last) begin
            if (pair_open)
                add_word({pair_byte, 8'h00});
            add_word(msg_length);
            e.checksum       = ~run_sum;
            e.message_length = msg_length;
            e.too_long       = length_clipped;
            owed_sums.push_back(e);
            clear_message();
        end
    endfunction

    // Compare one popped result with the oldest owed checksum.
    function void check_result(logic [15:0] checksum, logic [15:0] message_length,
                               logic too_long);
        t_sum_result e;
        if (owed_sums.size() == 0) begin
            $error("unexpected result: checksum %h, message_length %0d, too_long %0b",
                   checksum, message_length, too_long);
            mismatches++;
            return;
        end
        e = owed_sums.pop_front();
        if (checksum !== e.checksum) begin
            $error("checksum: expected %h, actual %h", e.checksum, checksum);
            mismatches++;
        end
        if (message_length !== e.message_length) begin
            $error("message_length: expected %0d, actual %0d", e.message_length,
                   message_length);
            mismatches++;
        end
        if (too_long !== e.too_long) begin
            $error("too_long: expected %0b, actual %0b", e.too_long, too_long);
            mismatches++;
        end
    endfunction
endclass

module icmpv6_checksum_builder_unit_tb;
    import icb_pkg::*;

    // Random phase size, in requests.
    localparam int unsigned RANDOM_REQUESTS = 1100;
    // Slowest correct run: about 1200 requests, each behind an idle gap and
    // each possibly closing a message whose result waits out a receiver stall
    // and the pipeline. The limit allows several times that.
    localparam int unsigned CYCLE_LIMIT = 200_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_op;
    logic [63:0] i_src_high;
    logic [63:0] i_src_low;
    logic [63:0] i_dst_high;
    logic [63:0] i_dst_low;
    logic [7:0]  i_msg_type;
    logic [7:0]  i_msg_code;
    logic [7:0]  i_data_byte;
    logic        i_last;
    logic        empty;
    logic        pop;
    logic [15:0] o_checksum;
    logic [15:0] o_message_length;
    logic        o_too_long;

    icmpv6_checksum_builder_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_op             (i_op),
        .i_src_high       (i_src_high),
        .i_src_low        (i_src_low),
        .i_dst_high       (i_dst_high),
        .i_dst_low        (i_dst_low),
        .i_msg_type       (i_msg_type),
        .i_msg_code       (i_msg_code),
        .i_data_byte      (i_data_byte),
        .i_last           (i_last),
        .empty            (empty),
        .pop              (pop),
        .o_checksum       (o_checksum),
        .o_message_length (o_message_length),
        .o_too_long       (o_too_long)
    );

    icmpv6_sum_tracker sum_book = new();

    int unsigned cycle_count;
    int unsigned sent_requests;
    int unsigned burst_left;
    int unsigned rx_cycle;
    int unsigned rx_stall_left;

    // Free-running clock, 2 ns period.
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Drive every input to a known value from time zero; hold reset low.
    initial begin
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_op        = OP_START;
        i_src_high  = '0;
        i_src_low   = '0;
        i_dst_high  = '0;
        i_dst_low   = '0;
        i_msg_type  = '0;
        i_msg_code  = '0;
        i_data_byte = '0;
        i_last      = 1'b0;
        pop         = 1'b0;
    end

    // Cycle counter: end the run if the block stops making progress.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("icmpv6_checksum_builder_unit test failed");
            $finish;
        end
    end

    // Receiver: pop on a pattern of its own, switching in turn between
    // always ready, coin-flip ready, and long stalls broken by short bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop           <= 1'b0;
            rx_cycle      <= 0;
            rx_stall_left <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            case ((rx_cycle / 300) % 3)
                0: begin
                    pop <= 1'b1;
                end
                1: begin
                    pop <= ($urandom_range(0, 1) == 1);
                end
                default: begin
                    if (rx_stall_left != 0) begin
                        pop           <= 1'b0;
                        rx_stall_left <= rx_stall_left - 1;
                    end else begin
                        pop <= 1'b1;
                        if ($urandom_range(0, 2) == 0)
                            rx_stall_left <= $urandom_range(4, 16);
                    end
                end
            endcase
        end
    end

    // Result monitor: check each result taken at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sum_book.check_result(o_checksum, o_message_length, o_too_long);
    end

    function automatic logic [63:0] pick_quad();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // Fill every field at random; the caller sets op and last.
    function automatic t_request random_request();
        t_request r;
        r.op        = OP_DATA;
        r.src_high  = pick_quad();
        r.src_low   = pick_quad();
        r.dst_high  = pick_quad();
        r.dst_low   = pick_quad();
        r.msg_type  = 8'($urandom);
        r.msg_code  = 8'($urandom);
        r.data_byte = 8'($urandom);
        r.last      = 1'b0;
        return r;
    endfunction

    // Push one request. The sender runs in bursts of 1 to 16 requests; most
    // bursts are preceded by a gap of idle cycles, some by none.
    task automatic send_request(t_request r);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                push <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        push        <= 1'b1;
        i_op        <= r.op;
        i_src_high  <= r.src_high;
        i_src_low   <= r.src_low;
        i_dst_high  <= r.dst_high;
        i_dst_low   <= r.dst_low;
        i_msg_type  <= r.msg_type;
        i_msg_code  <= r.msg_code;
        i_data_byte <= r.data_byte;
        i_last      <= r.last;
        // Hold the request until an edge sees full low.
        do @(posedge i_clk); while (full);
        sum_book.note_request(r);
        sent_requests++;
    endtask

    // Send a message: an optional start request, then n_data data bytes.
    // With closed low the message is left open, to be dropped by the next
    // start or continued by stray data.
    task automatic send_message(int unsigned n_data, bit with_start, bit closed);
        t_request r;
        if (with_start) begin
            r      = random_request();
            r.op   = OP_START;
            r.last = closed && (n_data == 0);
            send_request(r);
        end
        for (int unsigned i = 0; i < n_data; i++) begin
            r      = random_request();
            r.op   = OP_DATA;
            r.last = closed && (i == n_data - 1);
            send_request(r);
        end
    endtask

    // Send one request with fixed header fields and data byte.
    task automatic send_fixed(logic op, logic [63:0] quad, logic [7:0] msg_type,
                              logic [7:0] msg_code, logic [7:0] data_byte, logic last);
        t_request r;
        r.op        = op;
        r.src_high  = quad;
        r.src_low   = quad;
        r.dst_high  = quad;
        r.dst_low   = quad;
        r.msg_type  = msg_type;
        r.msg_code  = msg_code;
        r.data_byte = data_byte;
        r.last      = last;
        send_request(r);
    endtask

    initial begin
        int unsigned kind;
        int unsigned n_data;
        cycle_count   = 0;
        sent_requests = 0;
        burst_left    = 0;

        // Hold reset, then release it at a falling edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        // Stray data straight after reset: no pseudo-header, odd byte padded.
        send_fixed(OP_DATA, '0, 8'h00, 8'h00, 8'hAB, 1'b1);
        // Two stray bytes, one even pair.
        send_fixed(OP_DATA, '1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_fixed(OP_DATA, '0, 8'h00, 8'h00, 8'h00, 1'b1);
        // Empty messages at the address and header extremes.
        send_fixed(OP_START, '0, 8'h00, 8'h00, 8'h00, 1'b1);
        send_fixed(OP_START, '1, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_fixed(OP_START, 64'hFE80_0000_0000_0000, 8'h80, 8'h00, 8'h5A, 1'b1);
        // Odd data count: trailing byte padded with zero.
        send_fixed(OP_START, '1, 8'hFF, 8'h00, 8'h00, 1'b0);
        send_fixed(OP_DATA, '0, 8'h00, 8'h00, 8'hFF, 1'b0);
        send_fixed(OP_DATA, '0, 8'h00, 8'h00, 8'hFF, 1'b0);
        send_fixed(OP_DATA, '0, 8'h00, 8'h00, 8'h00, 1'b1);
        // Even data count.
        send_fixed(OP_START, '0, 8'h00, 8'hFF, 8'h00, 1'b0);
        send_fixed(OP_DATA, '1, 8'hFF, 8'hFF, 8'h00, 1'b0);
        send_fixed(OP_DATA, '1, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        // Start inside an open message: drop the old one, mid-pair.
        send_fixed(OP_START, '1, 8'h87, 8'h00, 8'h00, 1'b0);
        send_fixed(OP_DATA, '0, 8'h00, 8'h00, 8'h12, 1'b0);
        send_fixed(OP_DATA, '0, 8'h00, 8'h00, 8'h34, 1'b0);
        send_fixed(OP_DATA, '0, 8'h00, 8'h00, 8'h56, 1'b0);
        send_fixed(OP_START, 64'h0123_4567_89AB_CDEF, 8'h88, 8'h01, 8'h00, 1'b0);
        send_fixed(OP_DATA, '0, 8'h00, 8'h00, 8'h78, 1'b1);
        // Random content at both ends of the random part's shape.
        send_message(1, 1'b1, 1'b1);
        send_message(2, 1'b1, 1'b1);
        send_message(3, 1'b1, 1'b1);

        // Random part: mostly well-formed messages with random content, some
        // left open and dropped, some stray data with no start.
        sent_requests = 0;
        while (sent_requests < RANDOM_REQUESTS) begin
            kind = $urandom_range(0, 19);
            if ($urandom_range(0, 7) == 0)
                n_data = $urandom_range(0, 80);
            else
                n_data = $urandom_range(0, 20);
            if (kind < 2)
                send_message($urandom_range(0, 6), 1'b1, 1'b0);
            else if (kind == 2)
                send_message($urandom_range(1, 10), 1'b0, 1'b1);
            else
                send_message(n_data, 1'b1, 1'b1);
        end
        // Close whatever was left open so the last message is checked too.
        send_message(1, 1'b1, 1'b1);

        @(negedge i_clk);
        push <= 1'b0;

        // Drain: wait for every owed checksum, then a few pipeline lengths
        // more to catch a stray result.
        while (sum_book.pending() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (sum_book.mismatches == 0)
            $display("icmpv6_checksum_builder_unit test passed");
        else
            $display("icmpv6_checksum_builder_unit test failed");
        $finish;
    end

endmodule
